FILE: rtl/core/wsenc_pkg.sv
// ----------------------------------------------------------------------------
// wsenc_pkg
// Types and constants shared by the client WebSocket frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wsenc_pkg;

   // Field widths fixed by the frame format
   localparam int LenWidth   = 63;
   localparam int KeyWidth   = 32;
   localparam int RunMax     = 15;
   localparam int CountWidth = 4;

   // Header byte codes
   localparam logic [7:0] FIN_TEXT_BYTE = 8'h81;
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [7:0] LEN16_CODE    = 8'hFE;   // 126 with mask bit
   localparam logic [7:0] LEN64_CODE    = 8'hFF;   // 127 with mask bit

   // Length encoding limits
   localparam logic [LenWidth-1:0] SHORT_LEN_MAX = 63'd125;
   localparam logic [LenWidth-1:0] MID_LEN_MAX   = 63'd65535;

   // Position of the first key byte after each length form
   localparam logic [CountWidth-1:0] KEY_POS_SHORT = 4'd2;
   localparam logic [CountWidth-1:0] KEY_POS_MID   = 4'd4;
   localparam logic [CountWidth-1:0] KEY_POS_LONG  = 4'd10;

   // One request on the input channel
   typedef struct packed {
      logic [7:0]          payload_byte;
      logic                first_of_frame;
      logic [LenWidth-1:0] frame_length;
      logic [KeyWidth-1:0] mask_key;
   } req_type;

   // One result on the output channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_frame;
      logic       last_of_run;
   } rsp_type;

   // Frame state carried from request to request
   typedef struct packed {
      logic [KeyWidth-1:0] key;
      logic [LenWidth-1:0] remaining;
      logic [1:0]          phase;
   } frame_state_type;

   // Bytes produced by one request, entry 0 goes out first
   typedef struct packed {
      logic [RunMax-1:0][7:0]  bytes;
      logic [CountWidth-1:0]   count;
      logic                    last_of_frame;
   } run_type;

endpackage : wsenc_pkg

`default_nettype wire

FILE: rtl/core/websocket_client_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// websocket_client_frame_encoder_unit
// Client WebSocket text-frame encoder: header, mask key and masked payload,
// one encoded byte per result.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   req       req_valid/req_stall   req_payload (payload, first flag, length, key)
//   rsp       rsp_valid/rsp_stall   rsp_payload (byte, last of frame, last of run)
//
// A request is registered as a run of 0 to 15 bytes; the run drains one byte
// per cycle into the output register while the output does not stall. The
// next request is taken in the cycle its predecessor's last byte moves out,
// so payload bytes stream at one per cycle without output stalls. Reset
// clears the frame state, the run and the output valid flag. An output stall
// holds the output register and the run.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_client_frame_encoder_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire wsenc_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output wsenc_pkg::rsp_type   rsp_payload
);

   wsenc_pkg::frame_state_type state_ff, state_in;
   wsenc_pkg::frame_state_type state_built;
   wsenc_pkg::run_type         run_ff, run_in;
   wsenc_pkg::run_type         run_built;
   logic                       rsp_valid_ff, rsp_valid_in;
   wsenc_pkg::rsp_type         rsp_ff, rsp_in;

   logic out_free;
   logic move;
   logic accept;

   wsenc_run_builder u_builder (
      .req        (req_payload),
      .state_cur  (state_ff),
      .run        (run_built),
      .state_next (state_built)
   );

   // Handshake: move a byte when the output register frees up
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = (run_ff.count != '0) && out_free;
   assign req_stall = !((run_ff.count == '0) || ((run_ff.count == 4'd1) && out_free));
   assign accept    = req_valid && !req_stall;

   // Load a new run on accept, otherwise advance the current one
   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      if (accept) begin
         state_in = state_built;
         run_in   = run_built;
      end else if (move) begin
         run_in.bytes = run_ff.bytes >> 8;
         run_in.count = run_ff.count - 4'd1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (move) begin
         rsp_valid_in          = 1'b1;
         rsp_in.out_byte       = run_ff.bytes[0];
         rsp_in.last_of_run    = (run_ff.count == 4'd1);
         rsp_in.last_of_frame  = (run_ff.count == 4'd1) && run_ff.last_of_frame;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : websocket_client_frame_encoder_unit

`default_nettype wire

FILE: rtl/core/wsenc_run_builder.sv
// ----------------------------------------------------------------------------
// wsenc_run_builder
// Builds the byte run for one request and the frame state that follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsenc_run_builder (
   input  wire wsenc_pkg::req_type         req,
   input  wire wsenc_pkg::frame_state_type state_cur,
   output wsenc_pkg::run_type              run,
   output wsenc_pkg::frame_state_type      state_next
);

   logic [wsenc_pkg::LenWidth-1:0]   len;
   logic [63:0]                      len64;
   logic [wsenc_pkg::CountWidth-1:0] key_pos;
   logic [7:0]                       key_byte;

   assign len   = req.frame_length;
   assign len64 = {1'b0, len};

   // Select the key byte for the current phase
   always_comb begin
      case (state_cur.phase)
         2'd0:    key_byte = state_cur.key[31:24];
         2'd1:    key_byte = state_cur.key[23:16];
         2'd2:    key_byte = state_cur.key[15:8];
         2'd3:    key_byte = state_cur.key[7:0];
         default: key_byte = state_cur.key[31:24];
      endcase
   end

   // Assemble header and masked payload byte
   always_comb begin
      run        = '0;
      state_next = state_cur;
      key_pos    = wsenc_pkg::KEY_POS_SHORT;
      if (req.first_of_frame) begin
         state_next.key       = req.mask_key;
         state_next.phase     = 2'd0;
         state_next.remaining = len;
         run.bytes[0]         = wsenc_pkg::FIN_TEXT_BYTE;

         // Length field
         if (len <= wsenc_pkg::SHORT_LEN_MAX) begin
            run.bytes[1] = len[7:0] | wsenc_pkg::MASK_BIT;
            key_pos      = wsenc_pkg::KEY_POS_SHORT;
         end else if (len <= wsenc_pkg::MID_LEN_MAX) begin
            run.bytes[1] = wsenc_pkg::LEN16_CODE;
            run.bytes[2] = len[15:8];
            run.bytes[3] = len[7:0];
            key_pos      = wsenc_pkg::KEY_POS_MID;
         end else begin
            run.bytes[1] = wsenc_pkg::LEN64_CODE;
            for (int i = 0; i < 8; i++) begin
               run.bytes[2 + i] = len64[63 - 8*i -: 8];
            end
            key_pos = wsenc_pkg::KEY_POS_LONG;
         end

         // Mask key, first byte from the top
         for (int i = 0; i < 4; i++) begin
            run.bytes[key_pos + 4'(i)] = req.mask_key[31 - 8*i -: 8];
         end

         // Empty frame ends on the last key byte
         if (len == '0) begin
            run.count         = key_pos + 4'd4;
            run.last_of_frame = 1'b1;
         end else begin
            run.bytes[key_pos + 4'd4] = req.payload_byte ^ req.mask_key[31:24];
            run.count                 = key_pos + 4'd5;
            run.last_of_frame         = (len == 63'd1);
            state_next.remaining      = len - 63'd1;
            state_next.phase          = 2'd1;
         end
      end else if (state_cur.remaining != '0) begin
         run.bytes[0]         = req.payload_byte ^ key_byte;
         run.count            = 4'd1;
         run.last_of_frame    = (state_cur.remaining == 63'd1);
         state_next.remaining = state_cur.remaining - 63'd1;
         state_next.phase     = state_cur.phase + 2'd1;
      end
   end

endmodule : wsenc_run_builder

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the client WebSocket frame encoder. Directed
// requests hit the length-form boundaries, empty frames, dropped bytes and
// mid-frame restarts. Random frames follow, with random idling on both
// channels and one long output hold-off. Every encoded byte is compared with
// a local predictor of header, key and masked payload bytes.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Expected-byte store with its own copy of the frame state
   class frame_scoreboard;
      logic [wsenc_pkg::KeyWidth-1:0] key;
      logic [wsenc_pkg::LenWidth-1:0] remaining;
      logic [1:0]                     phase;
      wsenc_pkg::rsp_type             expected_bytes[$];
      int unsigned                    failures;

      function new();
         key       = '0;
         remaining = '0;
         phase     = '0;
         failures  = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic lof);
         wsenc_pkg::rsp_type e;
         e.out_byte      = b;
         e.last_of_frame = lof;
         e.last_of_run   = 1'b0;
         expected_bytes.insert(expected_bytes.size(), e);
      endfunction

      // Mask one payload byte with the rotating key byte
      function void push_payload(logic [7:0] b);
         logic [7:0] key_byte;
         key_byte  = key[8*(3-int'(phase)) +: 8];
         remaining = remaining - 1'b1;
         phase     = phase + 2'd1;
         push_byte(b ^ key_byte, remaining == '0);
      endfunction

      // Note an accepted request; return how many bytes it causes
      function int note_request(wsenc_pkg::req_type r);
         int unsigned start_size;
         logic [63:0] len_word;
         start_size = expected_bytes.size();
         if (r.first_of_frame) begin
            key       = r.mask_key;
            remaining = r.frame_length;
            phase     = '0;
            len_word  = {1'b0, r.frame_length};
            push_byte(wsenc_pkg::FIN_TEXT_BYTE, 1'b0);
            if (r.frame_length <= wsenc_pkg::SHORT_LEN_MAX) begin
               push_byte(wsenc_pkg::MASK_BIT | len_word[7:0], 1'b0);
            end else if (r.frame_length <= wsenc_pkg::MID_LEN_MAX) begin
               push_byte(wsenc_pkg::LEN16_CODE, 1'b0);
               push_byte(len_word[15:8], 1'b0);
               push_byte(len_word[7:0], 1'b0);
            end else begin
               push_byte(wsenc_pkg::LEN64_CODE, 1'b0);
               for (int i = 7; i >= 0; i--) push_byte(len_word[8*i +: 8], 1'b0);
            end
            // empty frame ends on the last key byte
            for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8], remaining == '0 && i == 0);
            if (remaining != '0) push_payload(r.payload_byte);
         end else if (remaining != '0) begin
            push_payload(r.payload_byte);
         end
         // flag the end of this request's run
         if (expected_bytes.size() > start_size) begin
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
         end
         return expected_bytes.size() - start_size;
      endfunction

      // Print the first 40 mismatches, count them all
      task report(string what);
         failures++;
         if (failures <= 40) $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_result(wsenc_pkg::rsp_type got);
         wsenc_pkg::rsp_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %h", got.out_byte));
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
         if (got.last_of_frame !== want.last_of_frame)
            report($sformatf("last_of_frame %b, want %b (byte %h)",
                             got.last_of_frame, want.last_of_frame, want.out_byte));
         if (got.last_of_run !== want.last_of_run)
            report($sformatf("last_of_run %b, want %b (byte %h)",
                             got.last_of_run, want.last_of_run, want.out_byte));
      endtask
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   wsenc_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   wsenc_pkg::rsp_type rsp_payload;

   frame_scoreboard book = new();
   int unsigned     requests_done = 0;
   bit              steady        = 1'b0;
   bit              hold_off_now  = 1'b0;
   int unsigned     stall_left    = 0;

   websocket_client_frame_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   // Receiver: random stall per byte, one long hold-off on demand
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) stall_left = steady ? 0 : $urandom_range(0, 10);
      if (hold_off_now) begin
         stall_left   = 300;
         hold_off_now = 1'b0;
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check each accepted byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_payload);
   end

   function automatic wsenc_pkg::req_type make_request(logic first,
                                                       logic [wsenc_pkg::LenWidth-1:0] len,
                                                       logic [wsenc_pkg::KeyWidth-1:0] mask,
                                                       logic [7:0] pb);
      wsenc_pkg::req_type r;
      r.payload_byte   = pb;
      r.first_of_frame = first;
      r.frame_length   = len;
      r.mask_key       = mask;
      return r;
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(wsenc_pkg::req_type r);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (book.note_request(r) != 0) requests_done++;
   endtask

   // Start a frame of the given length and send count requests of it
   task automatic send_frame(logic [wsenc_pkg::LenWidth-1:0] len, int unsigned count);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      send_request(make_request(1'b1, len, $urandom, 8'($urandom_range(0, 255))));
      for (int unsigned i = 1; i < count; i++) begin
         noise = {$urandom, $urandom};
         send_request(make_request(1'b0, noise[wsenc_pkg::LenWidth-1:0], $urandom,
                                   8'($urandom_range(0, 255))));
      end
   endtask

   initial begin : stimulus
      logic [63:0]                    draw;
      logic [wsenc_pkg::LenWidth-1:0] len;
      int unsigned                    pick;
      bit                             hold_done;
      bit                             drain_done;
      bit                             long_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      long_done  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: length-form boundaries, empty frame, dropped byte, restarts
      send_request(make_request(1'b1, 63'd0, 32'hFFFF_FFFF, 8'hFF));
      send_request(make_request(1'b0, '1, '1, 8'h5A));
      send_request(make_request(1'b1, 63'd1, 32'h0000_0000, 8'hFF));
      send_request(make_request(1'b1, wsenc_pkg::SHORT_LEN_MAX, 32'hA5C3_0F96, 8'h00));
      send_request(make_request(1'b0, '1, '1, 8'hFF));
      send_request(make_request(1'b1, wsenc_pkg::SHORT_LEN_MAX + 1'b1, 32'h1234_5678,
                                8'h80));
      send_request(make_request(1'b0, '0, '0, 8'h01));
      send_request(make_request(1'b1, wsenc_pkg::MID_LEN_MAX, 32'hFFFF_FFFF, 8'h7F));
      send_request(make_request(1'b1, wsenc_pkg::MID_LEN_MAX + 1'b1, 32'h8000_0001,
                                8'hFF));
      send_request(make_request(1'b1, '1, 32'hFFFF_FFFF, 8'h00));
      send_request(make_request(1'b0, '0, '0, 8'hC3));
      send_request(make_request(1'b1, 63'd6, 32'h0102_0304, 8'h00));
      send_request(make_request(1'b0, '0, '0, 8'hFF));
      send_request(make_request(1'b0, '0, '0, 8'h55));
      send_request(make_request(1'b0, '0, '0, 8'hAA));
      send_request(make_request(1'b0, '0, '0, 8'h0F));
      send_request(make_request(1'b0, '0, '0, 8'hF0));
      send_request(make_request(1'b0, '1, '1, 8'h33));
      send_request(make_request(1'b1, 63'd2, 32'hFFFF_FFFF, 8'hFF));
      send_request(make_request(1'b0, '0, '0, 8'h00));

      // Random frames, mostly complete, with restarts and dropped bytes
      while (requests_done < 330) begin
         steady = ($urandom_range(0, 5) == 0);
         pick   = $urandom_range(0, 99);
         if (!hold_done && requests_done >= 120) begin
            hold_off_now = 1'b1;
            hold_done    = 1'b1;
         end
         if (!drain_done && requests_done >= 220) begin
            // pause until every byte so far has come out
            req_valid <= 1'b0;
            do @(posedge clock); while (book.expected_bytes.size() != 0);
            drain_done = 1'b1;
         end
         if (!long_done && requests_done >= 40) begin
            // one complete frame in the 16-bit length form
            len = 63'($urandom_range(126, 136));
            send_frame(len, int'(len));
            long_done = 1'b1;
         end else if (pick < 65) begin
            len = 63'($urandom_range(0, 12));
            send_frame(len, (len == 0) ? 1 : int'(len));
         end else if (pick < 78) begin
            len = 63'($urandom_range(3, 40));
            send_frame(len, $urandom_range(1, int'(len) - 1));
         end else if (pick < 86) begin
            send_frame(63'($urandom_range(126, 65535)), $urandom_range(1, 4));
         end else if (pick < 93) begin
            draw = {$urandom, $urandom};
            len  = draw[wsenc_pkg::LenWidth-1:0];
            if (len <= wsenc_pkg::MID_LEN_MAX) len = len + wsenc_pkg::MID_LEN_MAX + 1'b1;
            send_frame(len, $urandom_range(1, 4));
         end else begin
            for (int i = 0; i < $urandom_range(1, 3); i++) begin
               draw = {$urandom, $urandom};
               send_request(make_request(1'b0, draw[wsenc_pkg::LenWidth-1:0], $urandom,
                                         8'($urandom_range(0, 255))));
            end
         end
      end

      // Drain and settle
      req_valid <= 1'b0;
      while (book.expected_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (book.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule : testbench
